@@ hw/rtl/stec_pkg.sv @@
// Shared types for the segment/triangle event classifier.
// Holds the event codes and the pipeline control bundle; no dependencies.
package stec_pkg;

    // Contact class given for every query.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STRICT   = 3'd1,
        EV_ENDPOINT = 3'd2,
        EV_BOUNDARY = 3'd3,
        EV_COPLANAR = 3'd4
    } t_event_kind;

    // Control bundle handed to each pipeline section.
    typedef struct packed {
        logic valid;    // a beat enters the section
        logic en;       // the whole pipeline advances this cycle
    } t_pipe_ctl;

endpackage

@@ hw/rtl/stec_geom.sv @@
// Geometry front end of the classifier: four register stages from the raw points
// to the plane distances and the edge sign tests. Depends on stec_pkg.
module stec_geom import stec_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_pipe_ctl                       i_ctl,
    input  logic [3*COORD_BITS-1:0]         i_seg_start,
    input  logic [3*COORD_BITS-1:0]         i_seg_end,
    input  logic [3*COORD_BITS-1:0]         i_tri_v0,
    input  logic [3*COORD_BITS-1:0]         i_tri_v1,
    input  logic [3*COORD_BITS-1:0]         i_tri_v2,
    output logic                            o_valid,
    output logic signed [3*COORD_BITS+5:0]  o_da,
    output logic signed [3*COORD_BITS+5:0]  o_db,
    output logic                            o_n_zero,
    output logic [2:0]                      o_edge_pos,
    output logic [2:0]                      o_edge_neg,
    output logic signed [COORD_BITS-1:0]    o_a [3],
    output logic signed [COORD_BITS:0]      o_delta [3]
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int NW = 2 * C + 3;
    localparam int MW = 3 * C + 4;
    localparam int PW = 3 * C + 6;

    function automatic logic signed [DW-1:0] dsub(input logic signed [C-1:0] a,
                                                  input logic signed [C-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    function automatic logic signed [NW-1:0] xdiff(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b,
                                                   input logic signed [DW-1:0] c,
                                                   input logic signed [DW-1:0] d);
        return NW'(a) * NW'(b) - NW'(c) * NW'(d);
    endfunction

    logic signed [C-1:0]  pt_a [3];
    logic signed [C-1:0]  pt_b [3];
    logic signed [C-1:0]  vtx  [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pt_a[k]   = i_seg_start[k*C +: C];
            pt_b[k]   = i_seg_end[k*C +: C];
            vtx[0][k] = i_tri_v0[k*C +: C];
            vtx[1][k] = i_tri_v1[k*C +: C];
            vtx[2][k] = i_tri_v2[k*C +: C];
        end
    end

    // Stage 1: coordinate differences.
    logic                 r1_valid;
    logic signed [DW-1:0] r1_e1 [3];
    logic signed [DW-1:0] r1_e2 [3];
    logic signed [DW-1:0] r1_dav [3];
    logic signed [DW-1:0] r1_dbv [3];
    logic signed [DW-1:0] r1_ee [3][3];
    logic signed [DW-1:0] r1_qb [3][3];
    logic signed [DW-1:0] r1_qa [3][3];
    logic signed [DW-1:0] r1_delta [3];
    logic signed [C-1:0]  r1_a [3];

    // Stage 2: normal and edge cross products.
    logic                 r2_valid;
    logic signed [NW-1:0] r2_n [3];
    logic signed [NW-1:0] r2_c [3][3];
    logic signed [DW-1:0] r2_dav [3];
    logic signed [DW-1:0] r2_dbv [3];
    logic signed [DW-1:0] r2_ee [3][3];
    logic signed [DW-1:0] r2_delta [3];
    logic signed [C-1:0]  r2_a [3];

    // Stage 3: dot product terms.
    logic                 r3_valid;
    logic                 r3_n_zero;
    logic signed [MW-1:0] r3_pa [3];
    logic signed [MW-1:0] r3_pb [3];
    logic signed [MW-1:0] r3_pe [3][3];
    logic signed [DW-1:0] r3_delta [3];
    logic signed [C-1:0]  r3_a [3];

    // Stage 4: sums and signs.
    logic                 r4_valid;
    logic signed [PW-1:0] r4_da;
    logic signed [PW-1:0] r4_db;
    logic                 r4_n_zero;
    logic [2:0]           r4_edge_pos;
    logic [2:0]           r4_edge_neg;
    logic signed [DW-1:0] r4_delta [3];
    logic signed [C-1:0]  r4_a [3];

    logic signed [PW-1:0] edge_sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            edge_sum[i] = PW'(r3_pe[i][0]) + PW'(r3_pe[i][1]) + PW'(r3_pe[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r1_valid <= i_ctl.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 3; k++) begin
                r1_e1[k]    <= dsub(vtx[1][k], vtx[0][k]);
                r1_e2[k]    <= dsub(vtx[2][k], vtx[0][k]);
                r1_dav[k]   <= dsub(pt_a[k], vtx[0][k]);
                r1_dbv[k]   <= dsub(pt_b[k], vtx[0][k]);
                r1_delta[k] <= dsub(pt_b[k], pt_a[k]);
                r1_a[k]     <= pt_a[k];
            end
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_ee[i][k] <= dsub(vtx[(i == 2) ? 0 : i + 1][k], vtx[i][k]);
                    r1_qb[i][k] <= dsub(pt_b[k], vtx[i][k]);
                    r1_qa[i][k] <= dsub(pt_a[k], vtx[i][k]);
                end
            end

            r2_n[0] <= xdiff(r1_e1[1], r1_e2[2], r1_e1[2], r1_e2[1]);
            r2_n[1] <= xdiff(r1_e1[2], r1_e2[0], r1_e1[0], r1_e2[2]);
            r2_n[2] <= xdiff(r1_e1[0], r1_e2[1], r1_e1[1], r1_e2[0]);
            for (int i = 0; i < 3; i++) begin
                r2_c[i][0] <= xdiff(r1_qb[i][1], r1_qa[i][2], r1_qb[i][2], r1_qa[i][1]);
                r2_c[i][1] <= xdiff(r1_qb[i][2], r1_qa[i][0], r1_qb[i][0], r1_qa[i][2]);
                r2_c[i][2] <= xdiff(r1_qb[i][0], r1_qa[i][1], r1_qb[i][1], r1_qa[i][0]);
                for (int k = 0; k < 3; k++) begin
                    r2_ee[i][k] <= r1_ee[i][k];
                end
            end
            for (int k = 0; k < 3; k++) begin
                r2_dav[k]   <= r1_dav[k];
                r2_dbv[k]   <= r1_dbv[k];
                r2_delta[k] <= r1_delta[k];
                r2_a[k]     <= r1_a[k];
            end

            r3_n_zero <= (r2_n[0] == '0) && (r2_n[1] == '0) && (r2_n[2] == '0);
            for (int k = 0; k < 3; k++) begin
                r3_pa[k]    <= MW'(r2_n[k]) * MW'(r2_dav[k]);
                r3_pb[k]    <= MW'(r2_n[k]) * MW'(r2_dbv[k]);
                r3_delta[k] <= r2_delta[k];
                r3_a[k]     <= r2_a[k];
                for (int i = 0; i < 3; i++) begin
                    r3_pe[i][k] <= MW'(r2_ee[i][k]) * MW'(r2_c[i][k]);
                end
            end

            r4_da     <= PW'(r3_pa[0]) + PW'(r3_pa[1]) + PW'(r3_pa[2]);
            r4_db     <= PW'(r3_pb[0]) + PW'(r3_pb[1]) + PW'(r3_pb[2]);
            r4_n_zero <= r3_n_zero;
            for (int i = 0; i < 3; i++) begin
                r4_edge_pos[i] <= (edge_sum[i] > 0);
                r4_edge_neg[i] <= (edge_sum[i] < 0);
            end
            for (int k = 0; k < 3; k++) begin
                r4_delta[k] <= r3_delta[k];
                r4_a[k]     <= r3_a[k];
            end
        end
    end

    assign o_valid    = r4_valid;
    assign o_da       = r4_da;
    assign o_db       = r4_db;
    assign o_n_zero   = r4_n_zero;
    assign o_edge_pos = r4_edge_pos;
    assign o_edge_neg = r4_edge_neg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_a[k]     = r4_a[k];
            o_delta[k] = r4_delta[k];
        end
    end

endmodule

@@ hw/rtl/stec_div.sv @@
// Pipelined restoring divider for the three crossing-point lanes, one quotient
// bit per register stage; carries the beat's class and start point. Depends on stec_pkg.
module stec_div import stec_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_pipe_ctl                       i_ctl,
    input  t_event_kind                     i_kind,
    input  logic [4*COORD_BITS+8:0]         i_u [3],
    input  logic                            i_neg [3],
    input  logic [3*COORD_BITS+7:0]         i_d2,
    input  logic signed [COORD_BITS-1:0]    i_a [3],
    output logic                            o_valid,
    output t_event_kind                     o_kind,
    output logic [COORD_BITS+2:0]           o_q [3],
    output logic                            o_neg [3],
    output logic signed [COORD_BITS-1:0]    o_a [3]
);

    localparam int C   = COORD_BITS;
    localparam int QB  = C + 3;
    localparam int UW  = 4 * C + 9;
    localparam int RW  = UW + 1;
    localparam int D2W = 3 * C + 8;

    logic                r_valid [QB];
    t_event_kind         r_kind  [QB];
    logic [RW-1:0]       r_rem   [QB][3];
    logic [QB-1:0]       r_q     [QB][3];
    logic                r_neg   [QB][3];
    logic signed [C-1:0] r_a     [QB][3];
    logic [D2W-1:0]      r_d2    [QB];

    logic [RW-1:0]       src_rem [QB][3];
    logic [QB-1:0]       src_q   [QB][3];
    logic [D2W-1:0]      src_d2  [QB];
    logic [RW-1:0]       n_rem   [QB][3];
    logic [QB-1:0]       n_q     [QB][3];

    always_comb begin
        for (int s = 0; s < QB; s++) begin
            src_d2[s] = (s == 0) ? i_d2 : r_d2[(s == 0) ? 0 : s - 1];
            for (int l = 0; l < 3; l++) begin
                src_rem[s][l] = (s == 0) ? RW'(i_u[l]) : r_rem[(s == 0) ? 0 : s - 1][l];
                src_q[s][l]   = (s == 0) ? '0 : r_q[(s == 0) ? 0 : s - 1][l];
                // Stage s decides quotient bit QB-1-s.
                if (src_rem[s][l] >= (RW'(src_d2[s]) << (QB - 1 - s))) begin
                    n_rem[s][l] = src_rem[s][l] - (RW'(src_d2[s]) << (QB - 1 - s));
                    n_q[s][l]   = src_q[s][l] | (QB'(1) << (QB - 1 - s));
                end else begin
                    n_rem[s][l] = src_rem[s][l];
                    n_q[s][l]   = src_q[s][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QB; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_ctl.en) begin
            r_valid[0] <= i_ctl.valid;
            for (int s = 1; s < QB; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int s = 0; s < QB; s++) begin
                r_d2[s]   <= src_d2[s];
                r_kind[s] <= (s == 0) ? i_kind : r_kind[(s == 0) ? 0 : s - 1];
                for (int l = 0; l < 3; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_q[s][l]   <= n_q[s][l];
                    r_neg[s][l] <= (s == 0) ? i_neg[l] : r_neg[(s == 0) ? 0 : s - 1][l];
                    r_a[s][l]   <= (s == 0) ? i_a[l] : r_a[(s == 0) ? 0 : s - 1][l];
                end
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_kind  = r_kind[QB-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_q[l]   = r_q[QB-1][l];
            o_neg[l] = r_neg[QB-1][l];
            o_a[l]   = r_a[QB-1][l];
        end
    end

endmodule

@@ hw/rtl/segment_triangle_event_classifier.sv @@
// Segment/triangle contact classifier, top level: classification, crossing-point
// set-up, output register. Depends on stec_pkg, stec_geom and stec_div.
//
// Usage. A query beat carries a segment (i_seg_start, i_seg_end) and a triangle
// (i_tri_v0..2), each point packed z:y:x as signed fixed-point coordinates of
// COORD_BITS bits, x in the low bits. It is taken at a rising edge where i_valid
// is high and o_stall is low. Each query gives exactly one result beat on
// o_valid/i_stall: the contact class o_event_kind and, for a strict crossing,
// the crossing point o_hit_x/y/z rounded to the nearest step (zero otherwise).
// Throughput is one query per cycle while o_stall is low. The pipeline is made of
// four geometry stages, four stages of classification and numerator set-up,
// COORD_BITS + 3 divider stages producing one quotient bit each, and the output
// register. The divider length is what sets the latency.
// The whole pipeline advances as one: while a result waits in the output
// register with i_stall high, every stage holds and o_stall is raised, so
// nothing is lost or repeated; bubbles travel as cleared valid bits.
// Reset (i_rst_n low at a clock edge) clears every valid bit; the block holds
// no other state and is ready in the first cycle after reset.
module segment_triangle_event_classifier import stec_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [3*COORD_BITS-1:0]       i_seg_start,
    input  logic [3*COORD_BITS-1:0]       i_seg_end,
    input  logic [3*COORD_BITS-1:0]       i_tri_v0,
    input  logic [3*COORD_BITS-1:0]       i_tri_v1,
    input  logic [3*COORD_BITS-1:0]       i_tri_v2,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_event_kind,
    output logic signed [COORD_BITS-1:0]  o_hit_x,
    output logic signed [COORD_BITS-1:0]  o_hit_y,
    output logic signed [COORD_BITS-1:0]  o_hit_z
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 3 * C + 6;       // plane distance width
    localparam int DENW = 3 * C + 7;       // crossing denominator width
    localparam int LOW  = (PW + 1) / 2;    // low slice of da for the split multiply
    localparam int HW   = PW - LOW;
    localparam int PLW  = LOW + 1 + DW;
    localparam int PHW  = HW + DW;
    localparam int NUMW = 4 * C + 7;       // da * (B - A)
    localparam int XW   = 4 * C + 9;       // 2N + D
    localparam int D2W  = 3 * C + 8;       // 2D
    localparam int QB   = C + 3;           // quotient bits

    // The pipeline moves only when the output register can move on.
    logic      pipe_en;
    t_pipe_ctl ctl;
    logic      r_out_valid;

    assign pipe_en   = !(r_out_valid && i_stall);
    assign ctl.en    = pipe_en;
    assign ctl.valid = i_valid;
    assign o_stall   = !pipe_en;

    // Geometry: plane distances and edge signs after four stages.
    logic                 g_valid;
    logic signed [PW-1:0] g_da;
    logic signed [PW-1:0] g_db;
    logic                 g_n_zero;
    logic [2:0]           g_edge_pos;
    logic [2:0]           g_edge_neg;
    logic signed [C-1:0]  g_a [3];
    logic signed [DW-1:0] g_delta [3];

    stec_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_seg_start (i_seg_start),
        .i_seg_end   (i_seg_end),
        .i_tri_v0    (i_tri_v0),
        .i_tri_v1    (i_tri_v1),
        .i_tri_v2    (i_tri_v2),
        .o_valid     (g_valid),
        .o_da        (g_da),
        .o_db        (g_db),
        .o_n_zero    (g_n_zero),
        .o_edge_pos  (g_edge_pos),
        .o_edge_neg  (g_edge_neg),
        .o_a         (g_a),
        .o_delta     (g_delta)
    );

    // Classification. When the distances have opposite signs the denominator
    // da - db has the sign of da, so the edge tests flip with da alone.
    t_event_kind n_kind;
    logic        da_zero;
    logic        db_zero;
    logic [2:0]  edge_p;
    logic [2:0]  edge_m;

    always_comb begin
        da_zero = (g_da == '0);
        db_zero = (g_db == '0);
        edge_p  = g_da[PW-1] ? g_edge_neg : g_edge_pos;
        edge_m  = g_da[PW-1] ? g_edge_pos : g_edge_neg;
        priority if (g_n_zero) begin
            n_kind = EV_BOUNDARY;
        end else if (da_zero && db_zero) begin
            n_kind = EV_COPLANAR;
        end else if (da_zero || db_zero) begin
            n_kind = EV_ENDPOINT;
        end else if (g_da[PW-1] == g_db[PW-1]) begin
            n_kind = EV_NONE;
        end else if ((&edge_p) || (&edge_m)) begin
            n_kind = EV_STRICT;
        end else if (edge_m == 3'b000) begin
            n_kind = EV_BOUNDARY;
        end else begin
            n_kind = EV_NONE;
        end
    end

    // Stage 5: class, denominator, and da * (B - A) as two partial products.
    logic                  r5_valid;
    t_event_kind           r5_kind;
    logic signed [DENW-1:0] r5_den;
    logic signed [PLW-1:0] r5_pl [3];
    logic signed [PHW-1:0] r5_ph [3];
    logic signed [C-1:0]   r5_a [3];

    // Stage 6: sign-corrected numerator and magnitude of the denominator.
    logic                   r6_valid;
    t_event_kind            r6_kind;
    logic signed [NUMW-1:0] r6_n [3];
    logic signed [DENW-1:0] r6_d;
    logic signed [C-1:0]    r6_a [3];

    // Stage 7: rounding offset added, 2N + D.
    logic                 r7_valid;
    t_event_kind          r7_kind;
    logic signed [XW-1:0] r7_x [3];
    logic [D2W-1:0]       r7_d2;
    logic signed [C-1:0]  r7_a [3];

    // Stage 8: floor division folded onto a non-negative dividend.
    logic                r8_valid;
    t_event_kind         r8_kind;
    logic [XW-1:0]       r8_u [3];
    logic                r8_neg [3];
    logic [D2W-1:0]      r8_d2;
    logic signed [C-1:0] r8_a [3];

    logic signed [NUMW-1:0] num_sum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num_sum[k] = (NUMW'(r5_ph[k]) <<< LOW) + NUMW'(r5_pl[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else if (pipe_en) begin
            r5_valid <= g_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_kind <= n_kind;
            r5_den  <= DENW'(g_da) - DENW'(g_db);
            for (int k = 0; k < 3; k++) begin
                r5_pl[k] <= PLW'(signed'({1'b0, g_da[LOW-1:0]})) * PLW'(g_delta[k]);
                r5_ph[k] <= PHW'(signed'(g_da[PW-1:LOW])) * PHW'(g_delta[k]);
                r5_a[k]  <= g_a[k];
            end

            r6_kind <= r5_kind;
            r6_d    <= r5_den[DENW-1] ? -r5_den : r5_den;
            for (int k = 0; k < 3; k++) begin
                r6_n[k] <= r5_den[DENW-1] ? -num_sum[k] : num_sum[k];
                r6_a[k] <= r5_a[k];
            end

            r7_kind <= r6_kind;
            r7_d2   <= D2W'(r6_d) << 1;
            for (int k = 0; k < 3; k++) begin
                r7_x[k] <= (XW'(r6_n[k]) <<< 1) + XW'(r6_d);
                r7_a[k] <= r6_a[k];
            end

            r8_kind <= r7_kind;
            r8_d2   <= r7_d2;
            for (int k = 0; k < 3; k++) begin
                // A negative quotient is the negated ceiling of the magnitude.
                r8_neg[k] <= r7_x[k][XW-1];
                r8_u[k]   <= r7_x[k][XW-1] ? (XW'(-r7_x[k]) + XW'(r7_d2) - XW'(1))
                                           : XW'(r7_x[k]);
                r8_a[k]   <= r7_a[k];
            end
        end
    end

    // Divider stages.
    logic                d_valid;
    t_event_kind         d_kind;
    logic [QB-1:0]       d_q [3];
    logic                d_neg [3];
    logic signed [C-1:0] d_a [3];
    t_pipe_ctl           div_ctl;

    assign div_ctl.en    = pipe_en;
    assign div_ctl.valid = r8_valid;

    stec_div #(.COORD_BITS(COORD_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_kind  (r8_kind),
        .i_u     (r8_u),
        .i_neg   (r8_neg),
        .i_d2    (r8_d2),
        .i_a     (r8_a),
        .o_valid (d_valid),
        .o_kind  (d_kind),
        .o_q     (d_q),
        .o_neg   (d_neg),
        .o_a     (d_a)
    );

    // Crossing point: start point plus the signed offset, kept only for strict hits.
    logic signed [QB:0]  q_s [3];
    logic signed [QB:0]  off [3];
    logic signed [C-1:0] n_hit [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_s[k]   = signed'({1'b0, d_q[k]});
            off[k]   = d_neg[k] ? -q_s[k] : q_s[k];
            n_hit[k] = (d_kind == EV_STRICT) ? (d_a[k] + C'(off[k])) : '0;
        end
    end

    t_event_kind         r_kind;
    logic signed [C-1:0] r_hit [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_kind <= d_kind;
            for (int k = 0; k < 3; k++) begin
                r_hit[k] <= n_hit[k];
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_hit_x      = r_hit[0];
    assign o_hit_y      = r_hit[1];
    assign o_hit_z      = r_hit[2];

endmodule

@@ verif/segment_triangle_event_classifier_tb.sv @@
// Self-checking testbench for segment_triangle_event_classifier.
// It depends on stec_pkg and the RTL only. An exact integer predictor runs on each accepted query,
// and the result beats are checked in order against it.
`timescale 1ns / 1ps

module segment_triangle_event_classifier_tb import stec_pkg::*;;

    localparam int CB         = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = CB + 40;
    localparam int HOLD_LEN   = 300;

    typedef logic signed [127:0] t_wint;

    typedef struct {
        t_event_kind     kind;
        logic [CB-1:0]   hx;
        logic [CB-1:0]   hy;
        logic [CB-1:0]   hz;
    } t_contact;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [3*CB-1:0]   i_seg_start = '0;
    logic [3*CB-1:0]   i_seg_end = '0;
    logic [3*CB-1:0]   i_tri_v0 = '0;
    logic [3*CB-1:0]   i_tri_v1 = '0;
    logic [3*CB-1:0]   i_tri_v2 = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_event_kind;
    logic signed [CB-1:0] o_hit_x, o_hit_y, o_hit_z;

    segment_triangle_event_classifier #(.COORD_BITS(CB)) i_dut (.*);

    always #4 i_clk = ~i_clk;

    // Results still owed by the block, oldest first.
    t_contact contact_q[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    logic     hold_active = 1'b0;

    // Cross product of two vectors at full width.
    function automatic void cross_w(input t_wint u[3], input t_wint v[3], output t_wint r[3]);
        r[0] = u[1] * v[2] - u[2] * v[1];
        r[1] = u[2] * v[0] - u[0] * v[2];
        r[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    function automatic t_wint dot_w(input t_wint u[3], input t_wint v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic int sign_w(input t_wint a);
        return (a < 0) ? -1 : ((a != 0) ? 1 : 0);
    endfunction

    // Exact contact class and crossing point for one query.
    function automatic t_contact classify_contact(input logic [3*CB-1:0] w[5]);
        t_wint    p[5][3];
        t_wint    e1[3], e2[3], nrm[3], d[3], e[3], qa[3], qb[3], c[3];
        t_wint    da, db, den, num, dd, twod, q;
        int       sa, sb, sd, s, npos, nneg, vi, vj;
        t_contact r;
        r.kind = EV_NONE;
        r.hx = '0;
        r.hy = '0;
        r.hz = '0;
        npos = 0;
        nneg = 0;
        for (int i = 0; i < 5; i++)
            for (int k = 0; k < 3; k++)
                p[i][k] = $signed(w[i][k*CB +: CB]);
        for (int k = 0; k < 3; k++) begin
            e1[k] = p[3][k] - p[2][k];
            e2[k] = p[4][k] - p[2][k];
        end
        cross_w(e1, e2, nrm);
        if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) begin
            r.kind = EV_BOUNDARY;
            return r;
        end
        for (int k = 0; k < 3; k++) d[k] = p[0][k] - p[2][k];
        da = dot_w(nrm, d);
        for (int k = 0; k < 3; k++) d[k] = p[1][k] - p[2][k];
        db = dot_w(nrm, d);
        sa = sign_w(da);
        sb = sign_w(db);
        if (sa == 0 && sb == 0) begin
            r.kind = EV_COPLANAR;
            return r;
        end
        if (sa == 0 || sb == 0) begin
            r.kind = EV_ENDPOINT;
            return r;
        end
        if (sa == sb) return r;
        den = da - db;
        sd = sign_w(den);
        // Edge tests are scaled by the sign of the crossing denominator.
        for (int i = 0; i < 3; i++) begin
            vi = 2 + i;
            vj = 2 + (i + 1) % 3;
            for (int k = 0; k < 3; k++) begin
                e[k]  = p[vj][k] - p[vi][k];
                qb[k] = p[1][k] - p[vi][k];
                qa[k] = p[0][k] - p[vi][k];
            end
            cross_w(qb, qa, c);
            s = sign_w(dot_w(e, c)) * sd;
            if (s > 0) npos++;
            else if (s < 0) nneg++;
        end
        if (npos == 3 || nneg == 3) begin
            r.kind = EV_STRICT;
            for (int k = 0; k < 3; k++) begin
                num = da * (p[1][k] - p[0][k]);
                dd = den;
                if (sd < 0) begin
                    num = -num;
                    dd = -den;
                end
                // Round to nearest, ties upward: floor((2*num + dd) / (2*dd)).
                num = num + num + dd;
                twod = dd + dd;
                q = num / twod;
                if (num < 0 && q * twod != num) q = q - 1;
                q = p[0][k] + q;
                if (k == 0) r.hx = q[CB-1:0];
                else if (k == 1) r.hy = q[CB-1:0];
                else r.hz = q[CB-1:0];
            end
            return r;
        end
        r.kind = (nneg == 0) ? EV_BOUNDARY : EV_NONE;
        return r;
    endfunction

    function automatic logic [3*CB-1:0] pt(input int x, input int y, input int z);
        logic [CB-1:0] px, py, pz;
        px = x[CB-1:0];
        py = y[CB-1:0];
        pz = z[CB-1:0];
        return {pz, py, px};
    endfunction

    // Offers one query beat and waits until the block takes it.
    task automatic send_query(input logic [3*CB-1:0] a, input logic [3*CB-1:0] b,
                              input logic [3*CB-1:0] v0, input logic [3*CB-1:0] v1,
                              input logic [3*CB-1:0] v2);
        logic [3*CB-1:0] w[5];
        w[0] = a;
        w[1] = b;
        w[2] = v0;
        w[3] = v1;
        w[4] = v2;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_seg_start <= a;
        i_seg_end   <= b;
        i_tri_v0    <= v0;
        i_tri_v1    <= v1;
        i_tri_v2    <= v2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        contact_q.insert(contact_q.size(), classify_contact(w));
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: checks each accepted beat and decides the stall for the next cycle.
    always @(posedge i_clk) begin
        t_contact exp_c;
        if (i_rst_n && o_valid && !i_stall) begin
            if (contact_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: kind %0d", $time,
                         o_event_kind);
                error_count++;
            end else begin
                exp_c = contact_q.pop_front();
                if (o_event_kind !== exp_c.kind) begin
                    $display("%0t: event_kind expected %0d actual %0d", $time,
                             exp_c.kind, o_event_kind);
                    error_count++;
                end
                if (o_hit_x !== exp_c.hx) begin
                    $display("%0t: hit_x expected %h actual %h", $time, exp_c.hx, o_hit_x);
                    error_count++;
                end
                if (o_hit_y !== exp_c.hy) begin
                    $display("%0t: hit_y expected %h actual %h", $time, exp_c.hy, o_hit_y);
                    error_count++;
                end
                if (o_hit_z !== exp_c.hz) begin
                    $display("%0t: hit_z expected %h actual %h", $time, exp_c.hz, o_hit_z);
                    error_count++;
                end
            end
        end
        i_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hand-picked queries: every contact class, rounding ties and the coordinate extremes.
    task automatic test_directed();
        logic [3*CB-1:0] t0, t1, t2;
        t0 = pt(0, 0, 0);
        t1 = pt(256, 0, 0);
        t2 = pt(0, 256, 0);
        send_query(pt(64, 64, 256), pt(64, 64, -256), t0, t0, t2);      // degenerate triangle
        send_query(pt(10, 10, 0), pt(500, -30, 0), t0, t1, t2);          // segment in the plane
        send_query(pt(64, 64, 0), pt(64, 64, 256), t0, t1, t2);          // one end on the plane
        send_query(pt(64, 64, 0), pt(900, 9, -256), t0, t1, t2);
        send_query(pt(64, 64, 100), pt(64, 64, 256), t0, t1, t2);        // both on one side
        send_query(pt(64, 64, 256), pt(64, 64, -256), t0, t1, t2);       // through the inside
        send_query(pt(64, 64, -256), pt(70, 60, 256), t0, t2, t1);       // reversed winding
        send_query(pt(128, 0, 256), pt(128, 0, -256), t0, t1, t2);       // across an edge
        send_query(pt(0, 0, 256), pt(0, 0, -256), t0, t1, t2);           // through a vertex
        send_query(pt(300, 300, 256), pt(300, 300, -256), t0, t1, t2);   // misses outside
        send_query(pt(64, 64, 1), pt(67, 65, -1), t0, t1, t2);           // rounding ties upward
        send_query(pt(64, 64, 1), pt(61, 63, -1), t0, t1, t2);
        send_query(pt(64, 64, -1), pt(61, 63, 2), t0, t1, t2);
        send_query(pt(-32000, -32000, 32767), pt(-32000, -32000, -32768),
                   pt(-32768, -32768, 0), pt(32767, -32768, 0), pt(-32768, 32767, 0));
        send_query(pt(32767, 32767, 32767), pt(-32768, -32768, -32768),
                   pt(-32768, 32767, 0), pt(32767, -32768, 0), pt(32767, 32767, -32768));
        send_query('1, '0, pt(32767, 0, 0), pt(0, 32767, 0), pt(0, 0, 32767));
        send_query('0, '1, '1, pt(-32768, -32768, -32768), pt(32767, 32767, 32767));
        send_query(pt(-32768, 0, 0), pt(32767, 0, 0), pt(0, -32768, -32768),
                   pt(0, 32767, -32768), pt(0, 0, 32767));
        go_quiet();
    endtask

    // Random queries. Most are built to cross a random, nearly flat triangle near its middle;
    // the rest are fully random words or tiny coordinates that hit edges and flat cases.
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        logic [3*CB-1:0] w[5];
        int cx, cy, mode;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(9);
            if (mode < 2) begin
                for (int i = 0; i < 5; i++) w[i] = {16'($urandom()), $urandom()};
            end else if (mode < 4) begin
                for (int i = 0; i < 5; i++)
                    w[i] = pt($urandom_range(8) - 4, $urandom_range(8) - 4,
                              $urandom_range(8) - 4);
            end else begin
                cx = $urandom_range(16000) - 8000;
                cy = $urandom_range(16000) - 8000;
                for (int i = 2; i < 5; i++)
                    w[i] = pt(cx + $urandom_range(16000) - 8000,
                              cy + $urandom_range(16000) - 8000,
                              $urandom_range(1000) - 500);
                cx = cx + $urandom_range(6000) - 3000;
                cy = cy + $urandom_range(6000) - 3000;
                w[0] = pt(cx, cy, $urandom_range(31000) + 1000);
                w[1] = pt(cx + $urandom_range(2000) - 1000, cy + $urandom_range(2000) - 1000,
                          -($urandom_range(31000) + 1000));
                if ($urandom_range(1)) begin
                    w[2] = w[0];
                    w[0] = w[1];
                    w[1] = w[2];
                    w[2] = pt(cx - 9000, cy - 9000, 0);
                end
            end
            send_query(w[0], w[1], w[2], w[3], w[4]);
        end
        go_quiet();
    endtask

    // The receiver holds off for a long stretch while queries keep coming, so the
    // pipeline fills and must stall its input without losing a beat. The hold-off
    // is counted in its own process.
    task automatic test_backpressure();
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_active <= 1'b0;
            end
        join_none
        test_random(120, 0, 0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 0, 0);
        test_random(350, 66, 0);
        test_random(350, 0, 66);
        test_random(350, 22, 22);
        test_backpressure();
        test_random(80, 0, 0);
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && contact_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
